[rtl/mlfd_pkg.sv]
`default_nettype none

package mlfd_pkg;

    // Frame layout of the fixed-length long frame.
    localparam int FRAME_LEN   = 21;
    localparam int SUM_FIRST   = 4;
    localparam int SUM_LAST    = 18;
    localparam int POS_START1  = 0;
    localparam int POS_L1      = 1;
    localparam int POS_L2      = 2;
    localparam int POS_START2  = 3;
    localparam int POS_IDENT   = 8;
    localparam int POS_STATUS  = 12;
    localparam int POS_DIF     = 13;
    localparam int POS_VIF     = 14;
    localparam int POS_DATA    = 15;
    localparam int POS_CSUM    = 19;
    localparam int POS_STOP    = 20;

    localparam int COUNT_W     = $clog2(FRAME_LEN + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] STOP_BYTE  = 8'h16;
    localparam logic [3:0] BCD_MAX    = 4'd9;

    typedef enum logic [2:0] {
        RES_OK           = 3'd0,
        RES_SHORT        = 3'd1,
        RES_BAD_START    = 3'd2,
        RES_LEN_MISMATCH = 3'd3,
        RES_BAD_STOP     = 3'd4,
        RES_CHECKSUM     = 3'd5
    } result_code_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_buffer;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [26:0] meter_id;
        logic [26:0] reading;
        logic [3:0]  decimal_position;
        logic [3:0]  caliber_code;
        logic        overflow_flag;
        logic        reverse_flow_flag;
        logic        leak_flag;
        logic [4:0]  battery_bits;
    } result_item_t;

    // One classified frame as handed from the front to the back.
    typedef struct packed {
        result_code_t code;
        logic [31:0]  ident;
        logic [31:0]  data;
        logic [7:0]   status;
        logic [7:0]   dif;
        logic [7:0]   vif;
    } frame_rec_t;

endpackage

`default_nettype wire

[rtl/mbus_long_frame_meter_decoder.sv]
// Decoder for fixed 21-byte M-Bus long frames, fed one received byte per transfer.
// The byte channel (byte_valid, byte_ready, byte_data) carries the byte and an
// end_of_buffer mark. Only the transfer that carries end_of_buffer produces a
// result, one per buffer, on the result channel (result_valid, result_ready,
// result_data): a status code, then meter ID and reading in binary and the
// status, DIF and VIF fields, all zero unless the frame passed every check.
// Bytes past the 21st of a buffer are dropped, but their end mark still counts.
// Throughput is one byte per cycle while byte_ready is high, and one result per
// cycle when every byte ends a buffer and the receiver keeps up. A result passes
// through the frame queue and the BCD conversion stages A and B, after which it
// waits in the output register.
// When the receiver stalls, results back up through the conversion stages
// into the frame queue; byte_ready drops only once that queue is full.
// Reset empties the queue and the pipeline and starts a new frame; the kept
// frame bytes are not cleared, since each frame rewrites what it reads.
`default_nettype none

module mbus_long_frame_meter_decoder
    import mlfd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_ready,
    input  wire byte_item_t   byte_data,
    output logic              result_valid,
    input  wire logic         result_ready,
    output result_item_t      result_data
);

    logic       push_valid;
    logic       push_ready;
    frame_rec_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    frame_rec_t pop_data;

    mlfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .rec_valid  (push_valid),
        .rec_ready  (push_ready),
        .rec_data   (push_data)
    );

    mlfd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mlfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (pop_valid),
        .rec_ready    (pop_ready),
        .rec_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

[rtl/mlfd_front.sv]
`default_nettype none

module mlfd_front
    import mlfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire byte_item_t byte_data,
    output logic            rec_valid,
    input  wire logic       rec_ready,
    output frame_rec_t      rec_data
);

    logic [7:0]         frame_reg [FRAME_LEN];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         sum_reg;
    logic [7:0]         sum_next;
    logic [7:0]         view [FRAME_LEN];
    logic               room;
    logic               in_sum;
    logic               accept;
    result_code_t       code;

    assign byte_ready = rec_ready;
    assign accept     = byte_valid && byte_ready;
    assign room       = count_reg < COUNT_W'(FRAME_LEN);
    assign in_sum     = room && (count_reg >= COUNT_W'(SUM_FIRST))
                        && (count_reg <= COUNT_W'(SUM_LAST));

    // The frame as it stands once the current byte is kept.
    always_comb
    begin
        for (int p = 0; p < FRAME_LEN; p++)
        begin
            if (room && (count_reg == COUNT_W'(p)))
                view[p] = byte_data.rx_byte;
            else
                view[p] = frame_reg[p];
        end
    end

    assign count_next = room ? count_reg + COUNT_W'(1) : count_reg;
    assign sum_next   = in_sum ? sum_reg + byte_data.rx_byte : sum_reg;

    always_comb
    begin
        priority if (count_next < COUNT_W'(FRAME_LEN))
            code = RES_SHORT;
        else if ((view[POS_START1] != START_BYTE) || (view[POS_START2] != START_BYTE))
            code = RES_BAD_START;
        else if (view[POS_L1] != view[POS_L2])
            code = RES_LEN_MISMATCH;
        else if (view[POS_STOP] != STOP_BYTE)
            code = RES_BAD_STOP;
        else if (sum_next != view[POS_CSUM])
            code = RES_CHECKSUM;
        else
            code = RES_OK;
    end

    assign rec_valid       = byte_valid && byte_data.end_of_buffer;
    assign rec_data.code   = code;
    assign rec_data.ident  = {view[POS_IDENT+3], view[POS_IDENT+2],
                              view[POS_IDENT+1], view[POS_IDENT]};
    assign rec_data.data   = {view[POS_DATA+3], view[POS_DATA+2],
                              view[POS_DATA+1], view[POS_DATA]};
    assign rec_data.status = view[POS_STATUS];
    assign rec_data.dif    = view[POS_DIF];
    assign rec_data.vif    = view[POS_VIF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (accept)
        begin
            if (byte_data.end_of_buffer)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && room)
            frame_reg[count_reg] <= byte_data.rx_byte;
    end

endmodule

`default_nettype wire

[rtl/mlfd_queue.sv]
`default_nettype none

module mlfd_queue
    import mlfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire frame_rec_t push_data,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output frame_rec_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = fill_reg != CNT_W'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[rtl/mlfd_back.sv]
`default_nettype none

module mlfd_back
    import mlfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rec_valid,
    output logic            rec_ready,
    input  wire frame_rec_t rec_data,
    output logic            result_valid,
    input  wire logic       result_ready,
    output result_item_t    result_data
);

    // Stage A: each BCD byte becomes a value of two digits.
    logic         a_valid_reg;
    result_code_t a_code_reg;
    logic [7:0]   a_status_reg;
    logic [3:0]   a_dif_reg;
    logic [3:0]   a_vif_reg;
    logic [6:0]   a_id_reg [4];
    logic [6:0]   a_da_reg [4];
    logic         a_id_bad_reg;
    logic         a_da_bad_reg;

    // Stage B: pairs of bytes become values of four digits.
    logic         b_valid_reg;
    result_code_t b_code_reg;
    logic [7:0]   b_status_reg;
    logic [3:0]   b_dif_reg;
    logic [3:0]   b_vif_reg;
    logic [13:0]  b_id_hi_reg;
    logic [13:0]  b_id_lo_reg;
    logic [13:0]  b_da_hi_reg;
    logic [13:0]  b_da_lo_reg;
    logic         b_id_bad_reg;
    logic         b_da_bad_reg;

    logic         out_valid_reg;
    result_item_t out_reg;

    logic         c_ready;
    logic         b_ready;
    logic         a_ready;
    logic [6:0]   id_pair [4];
    logic [6:0]   da_pair [4];
    logic         id_bad;
    logic         da_bad;
    logic         ok;
    logic [26:0]  id_full;
    logic [26:0]  da_full;

    assign c_ready   = !out_valid_reg || result_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign rec_ready = a_ready;

    always_comb
    begin
        id_bad = 1'b0;
        da_bad = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            id_pair[i] = 7'(8'(rec_data.ident[8*i+4 +: 4]) * 8'd10
                            + 8'(rec_data.ident[8*i +: 4]));
            da_pair[i] = 7'(8'(rec_data.data[8*i+4 +: 4]) * 8'd10
                            + 8'(rec_data.data[8*i +: 4]));
            if ((rec_data.ident[8*i+4 +: 4] > BCD_MAX) || (rec_data.ident[8*i +: 4] > BCD_MAX))
                id_bad = 1'b1;
            if ((rec_data.data[8*i+4 +: 4] > BCD_MAX) || (rec_data.data[8*i +: 4] > BCD_MAX))
                da_bad = 1'b1;
        end
    end

    assign ok      = b_code_reg == RES_OK;
    assign id_full = 27'(b_id_hi_reg) * 27'd10000 + 27'(b_id_lo_reg);
    assign da_full = 27'(b_da_hi_reg) * 27'd10000 + 27'(b_da_lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= rec_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && rec_valid)
        begin
            a_code_reg   <= rec_data.code;
            a_status_reg <= rec_data.status;
            a_dif_reg    <= rec_data.dif[7:4];
            a_vif_reg    <= rec_data.vif[3:0];
            a_id_reg     <= id_pair;
            a_da_reg     <= da_pair;
            a_id_bad_reg <= id_bad;
            a_da_bad_reg <= da_bad;
        end
        if (b_ready && a_valid_reg)
        begin
            b_code_reg   <= a_code_reg;
            b_status_reg <= a_status_reg;
            b_dif_reg    <= a_dif_reg;
            b_vif_reg    <= a_vif_reg;
            b_id_hi_reg  <= 14'(a_id_reg[3]) * 14'd100 + 14'(a_id_reg[2]);
            b_id_lo_reg  <= 14'(a_id_reg[1]) * 14'd100 + 14'(a_id_reg[0]);
            b_da_hi_reg  <= 14'(a_da_reg[3]) * 14'd100 + 14'(a_da_reg[2]);
            b_da_lo_reg  <= 14'(a_da_reg[1]) * 14'd100 + 14'(a_da_reg[0]);
            b_id_bad_reg <= a_id_bad_reg;
            b_da_bad_reg <= a_da_bad_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            // Every field but the code reads zero on a failed frame.
            out_reg.result_code       <= 3'(b_code_reg);
            out_reg.meter_id          <= (ok && !b_id_bad_reg) ? id_full : '0;
            out_reg.reading           <= (ok && !b_da_bad_reg) ? da_full : '0;
            out_reg.decimal_position  <= ok ? b_vif_reg : '0;
            out_reg.caliber_code      <= ok ? b_dif_reg : '0;
            out_reg.overflow_flag     <= ok && b_status_reg[7];
            out_reg.reverse_flow_flag <= ok && b_status_reg[6];
            out_reg.leak_flag         <= ok && b_status_reg[5];
            out_reg.battery_bits      <= ok ? b_status_reg[4:0] : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

`default_nettype wire
